>>> design/lc2k_pkg.sv
// ----------------------------------------------------------------------------
// lc2k_pkg
// Types, opcodes and helpers shared by the LC-2K pipeline block.
// ----------------------------------------------------------------------------
package lc2k_pkg;

  localparam int MemWords  = 65536;
  localparam int MemAw     = $clog2(MemWords);
  localparam int RegCount  = 8;
  localparam int RegAw     = 3;

  localparam logic [31:0] NoopWord = 32'h01c0_0000;

  typedef enum logic [2:0] {
    OP_ADD  = 3'd0,
    OP_NOR  = 3'd1,
    OP_LW   = 3'd2,
    OP_SW   = 3'd3,
    OP_BEQ  = 3'd4,
    OP_JALR = 3'd5,
    OP_HALT = 3'd6,
    OP_NOOP = 3'd7
  } opcode_t;

  typedef enum logic {
    CMD_LOAD = 1'b0,
    CMD_STEP = 1'b1
  } command_t;

  typedef struct packed {
    logic [0:0]  command;
    logic [15:0] address;
    logic [31:0] word;
  } in_word_t;

  typedef struct packed {
    logic [15:0] pc;
    logic [31:0] cycle_count;
    logic        halted;
    logic        stalled;
    logic        flushed;
    logic        writeback_valid;
    logic [2:0]  writeback_register;
    logic [31:0] writeback_value;
    logic        store_valid;
    logic [15:0] store_address;
    logic [31:0] store_value;
  } out_word_t;

  // memory request from the core to the memory unit
  typedef struct packed {
    logic              we;
    logic [MemAw-1:0]  waddr;
    logic [31:0]       wdata;
    logic              dwe;
    logic [MemAw-1:0]  iaddr;
    logic [MemAw-1:0]  daddr;
  } mem_req_t;

  function automatic opcode_t opc(input logic [31:0] w);
    return opcode_t'(w[24:22]);
  endfunction

  function automatic logic [MemAw-1:0] midx(input logic [15:0] a);
    return MemAw'(a);
  endfunction

endpackage

>>> design/lc2k_if.sv
// ----------------------------------------------------------------------------
// lc2k_if
// Valid/ready channel carrying one word of a given payload type.
// ----------------------------------------------------------------------------
interface lc2k_if #(parameter type T = logic) (input logic clk);
  logic valid;
  logic ready;
  T     payload;
  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

>>> design/lc2k_mem.sv
// ----------------------------------------------------------------------------
// lc2k_mem
// Instruction and data memories with registered reads.
// ----------------------------------------------------------------------------
module lc2k_mem (
  input  logic                clk,
  input  lc2k_pkg::mem_req_t  req,
  output logic [31:0]         idata,
  output logic [31:0]         ddata
);
  import lc2k_pkg::*;

  logic [31:0] imem [MemWords];
  logic [31:0] dmem [MemWords];

  always_ff @(posedge clk) begin
    if (req.we) begin
      imem[req.waddr] <= req.wdata;
    end
    if (req.we || req.dwe) begin
      dmem[req.waddr] <= req.wdata;
    end
    idata <= imem[req.iaddr];
    ddata <= dmem[req.daddr];
  end
endmodule

>>> design/lc2k_five_stage_pipeline_top.sv
// ----------------------------------------------------------------------------
// lc2k_five_stage_pipeline_top
// LC-2K five-stage pipeline emulator driven by load and step words.
// ----------------------------------------------------------------------------
// Usage:
//   in  : command/address/word. Load (command 0) writes one word into both
//         instruction and data memory. Step (command 1) advances one cycle.
//   out : one result word per input word: pc, cycle count, halted, stall and
//         flush flags, register write and store of that cycle.
// Timing: a load writes memory and registers its result in its accept cycle.
//   A step has two phases: the first presents the pc and the EX/MEM address
//   to the synchronous memories, the second uses the read data and, unless
//   halted, updates all pipeline latches, as the memory reads are registered.
// Output: the result is registered at the end of the last phase.
// A result waits in the output register while the next input is accepted;
//   when the receiver stalls with the output full, input is held off.
// Reset: latches hold noop, registers, pc, cycle count and halt are zero.
//   Memory contents are undefined until loaded.
// Forwarding: EX takes operands from EX/MEM (add/nor), MEM/WB and WBEND.
// ----------------------------------------------------------------------------
module lc2k_five_stage_pipeline_top (
  input logic clk,
  input logic rst,
  lc2k_if.sink   in,
  lc2k_if.source out
);
  import lc2k_pkg::*;

  // pipeline latches
  logic [31:0] fd_instr;  logic [15:0] fd_pc1;
  logic [31:0] de_instr;  logic [15:0] de_pc1;
  logic [31:0] de_a, de_b, de_off;
  logic [31:0] em_instr;  logic [15:0] em_target;
  logic [31:0] em_alu, em_b;
  logic [31:0] mw_instr, mw_data;
  logic [31:0] we_instr, we_data;
  logic [31:0] rf [RegCount];
  logic [15:0] pc;
  logic [31:0] cycles;
  logic        halt;

  logic        busy;       // step in second phase
  logic        out_full;
  out_word_t   out_q;
  out_word_t   out_next;

  mem_req_t    req;
  logic [31:0] idata, ddata;

  lc2k_mem u_mem (.clk(clk), .req(req), .idata(idata), .ddata(ddata));

  logic take;
  assign in.ready = !busy && (!out_full || out.ready);
  assign take     = in.valid && in.ready;

  // --- combinational step, evaluated in the second phase ---
  opcode_t fo, dop, eo;
  logic [2:0] d_lw;
  logic stl, fl, wbv, stv;
  logic [2:0] wbr;
  logic [31:0] fa_v, fb_v;
  logic [31:0] nfd_instr, nde_instr, nem_instr;
  logic [15:0] nfd_pc1, npc;
  logic [31:0] fwa, fwb, alu;
  logic [31:0] nmw_data, nwe_data;
  logic ua, ub;

  function automatic logic dest(input logic [31:0] w, input logic with_lw,
                                input logic [2:0] r);
    opcode_t o;
    o = opc(w);
    if (o == OP_ADD || o == OP_NOR) return w[2:0] == r;
    if (with_lw && o == OP_LW) return w[18:16] == r;
    return 1'b0;
  endfunction

  function automatic logic [31:0] fwd(input logic [2:0] r, input logic [31:0] v,
      input logic [31:0] ei, input logic [31:0] ea, input logic [31:0] mi,
      input logic [31:0] md, input logic [31:0] wi, input logic [31:0] wd);
    if (dest(ei, 1'b0, r)) return ea;
    if (dest(mi, 1'b1, r)) return md;
    if (dest(wi, 1'b1, r)) return wd;
    return v;
  endfunction

  always_comb begin
    fo  = opc(fd_instr);
    dop = opc(de_instr);
    eo  = opc(em_instr);
    d_lw = de_instr[18:16];
    ua = fd_instr[24:22] <= 3'd4;
    ub = fo == OP_ADD || fo == OP_NOR || fo == OP_SW || fo == OP_BEQ;
    stl = (dop == OP_LW) && ((ua && fd_instr[21:19] == d_lw) ||
                             (ub && fd_instr[18:16] == d_lw));
    fl  = (eo == OP_BEQ) && (em_alu == 32'd1);
    npc = pc + 16'd1;
    nfd_instr = idata;
    nfd_pc1   = npc;
    nde_instr = fd_instr;
    if (stl) begin
      nfd_instr = fd_instr;
      nfd_pc1   = fd_pc1;
      npc       = pc;
      nde_instr = NoopWord;
    end
    fwa = fwd(de_instr[21:19], de_a, em_instr, em_alu, mw_instr, mw_data,
              we_instr, we_data);
    fwb = fwd(de_instr[18:16], de_b, em_instr, em_alu, mw_instr, mw_data,
              we_instr, we_data);
    case (dop)
      OP_ADD:        alu = fwa + fwb;
      OP_NOR:        alu = ~(fwa | fwb);
      OP_LW, OP_SW:  alu = fwa + de_off;
      OP_BEQ:        alu = {31'd0, fwa == fwb};
      default:       alu = {16'd0, de_pc1};
    endcase
    nem_instr = de_instr;
    stv = (eo == OP_SW);
    case (eo)
      OP_ADD, OP_NOR: nmw_data = em_alu;
      OP_LW:          nmw_data = ddata;
      default:        nmw_data = mw_data;
    endcase
    if (fl) begin
      stl = 1'b0;
      npc = em_target;
      nfd_instr = NoopWord;
      nfd_pc1 = 16'd0;
      nde_instr = NoopWord;
      nem_instr = NoopWord;
    end
    wbv = (opc(mw_instr) == OP_ADD || opc(mw_instr) == OP_NOR ||
           opc(mw_instr) == OP_LW);
    wbr = (opc(mw_instr) == OP_LW) ? mw_instr[18:16] : mw_instr[2:0];
    nwe_data = wbv ? mw_data : we_data;
    fa_v = rf[fd_instr[21:19]];
    fb_v = rf[fd_instr[18:16]];
  end

  // result word: load and halted step report state only
  always_comb begin
    out_next = '0;
    out_next.pc = pc;
    out_next.cycle_count = cycles;
    out_next.halted = halt;
    if (busy && !halt) begin
      out_next.pc = npc;
      out_next.cycle_count = (cycles != 32'hffff_ffff) ? cycles + 32'd1 : cycles;
      out_next.halted = (opc(em_instr) == OP_HALT);
      out_next.stalled = stl;
      out_next.flushed = fl;
      out_next.writeback_valid = wbv;
      out_next.writeback_register = wbv ? wbr : 3'd0;
      out_next.writeback_value = wbv ? mw_data : 32'd0;
      out_next.store_valid = stv;
      out_next.store_address = stv ? em_alu[15:0] : 16'd0;
      out_next.store_value = stv ? em_b : 32'd0;
    end
  end

  logic do_step;
  assign do_step = busy;

  // memory requests: load writes and read addresses presented in the accept cycle, stores in the second phase
  always_comb begin
    req.we    = take && (in.payload.command == CMD_LOAD);
    req.waddr = midx(in.payload.address);
    req.wdata = in.payload.word;
    req.iaddr = midx(pc);
    req.daddr = midx(em_alu[15:0]);
    req.dwe   = 1'b0;
    if (do_step && !halt && stv) begin
      req.dwe   = 1'b1;
      req.waddr = midx(em_alu[15:0]);
      req.wdata = em_b;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b0;
      out_full <= 1'b0;
      pc       <= '0;
      cycles   <= '0;
      halt     <= 1'b0;
      fd_instr <= NoopWord; fd_pc1 <= '0;
      de_instr <= NoopWord; de_pc1 <= '0; de_a <= '0; de_b <= '0; de_off <= '0;
      em_instr <= NoopWord; em_target <= '0; em_alu <= '0; em_b <= '0;
      mw_instr <= NoopWord; mw_data <= '0;
      we_instr <= NoopWord; we_data <= '0;
      for (int i = 0; i < RegCount; i++) rf[i] <= '0;
    end else begin
      // load answers at once, a step answers after its second phase
      if ((take && in.payload.command == CMD_LOAD) || busy) begin
        out_full <= 1'b1;
        out_q    <= out_next;
      end else if (out_full && out.ready) begin
        out_full <= 1'b0;
      end
      if (take && in.payload.command == CMD_STEP) begin
        busy <= 1'b1;
      end else if (busy) begin
        busy <= 1'b0;
      end
      if (busy && !halt) begin
        // advance every latch
        fd_instr <= nfd_instr; fd_pc1 <= nfd_pc1;
        de_instr <= nde_instr;
        de_pc1 <= (stl || fl) ? 16'd0 : fd_pc1;
        de_a   <= (stl || fl) ? 32'd0 : fa_v;
        de_b   <= (stl || fl) ? 32'd0 : fb_v;
        de_off <= (stl || fl) ? 32'd0 : {{16{fd_instr[15]}}, fd_instr[15:0]};
        em_instr  <= nem_instr;
        em_target <= fl ? 16'd0 : de_pc1 + de_off[15:0];
        em_alu    <= fl ? 32'd0 : alu;
        em_b      <= fl ? 32'd0 : fwb;
        mw_instr <= em_instr;
        mw_data  <= nmw_data;
        we_instr <= mw_instr;
        we_data  <= nwe_data;
        if (wbv) rf[wbr] <= mw_data;
        pc <= npc;
        if (cycles != 32'hffff_ffff) cycles <= cycles + 32'd1;
        if (opc(em_instr) == OP_HALT) halt <= 1'b1;
      end
    end
  end

  assign out.valid   = out_full;
  assign out.payload = out_q;

  a_busy_blocks: assert property (@(posedge clk) disable iff (rst)
    busy |-> !in.ready) else $error("input taken mid step");
  a_busy_one: assert property (@(posedge clk) disable iff (rst)
    busy |=> !busy) else $error("step longer than two clocks");
  a_halt_sticky: assert property (@(posedge clk) disable iff (rst)
    halt |=> halt) else $error("halt cleared");
  a_no_both: assert property (@(posedge clk) disable iff (rst)
    (busy && fl) |-> !stl) else $error("stall with flush");
endmodule
